// ----- hdl/euler_to_quaternion_defines.svh -----
// assertion helpers for the euler to quaternion block
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// property holds every clock edge outside reset
`define E2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication, consequent checked in the next cycle
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/e2q_pkg.sv -----
package e2q_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned TurnUnits = 92160;
  localparam int unsigned QuarterUnits = 23040;
  localparam int unsigned HalfUnits = 46080;
  localparam logic [32:0] DegToRadQ46 = 33'd4797524518;
  localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = 2;

  typedef logic signed [33:0] cval_t;

  typedef struct packed {
    logic [16:0] r;
    logic        flip;
  } fold_t;

  typedef struct packed {
    fold_t roll;
    fold_t pitch;
    fold_t yaw;
  } front_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd843314856;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043836;
      5'd3: v = 34'sd133525158;
      5'd4: v = 34'sd67021686;
      5'd5: v = 34'sd33543515;
      5'd6: v = 34'sd16775850;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194282;
      5'd9: v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/e2q_stream_if.sv -----
interface e2q_stream_if #(
  parameter int unsigned Width = 8
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/e2q_front.sv -----
module e2q_front import e2q_pkg::*; #(
  parameter int unsigned AngleWidth = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [AngleWidth-1:0] roll_i,
  input  logic signed [AngleWidth-1:0] pitch_i,
  input  logic signed [AngleWidth-1:0] yaw_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output front_t                       item_o
);

  localparam int unsigned RecipSh = 40;
  localparam logic [23:0] TurnRecip = 24'd11930465;
  localparam int unsigned ProdW = AngleWidth + 26;
  localparam logic signed [ProdW-1:0] TurnS = ProdW'(TurnUnits);

  logic   valid_q;
  front_t item_q;

  // residue mod 92160 by reciprocal multiply with a short correction, then fold to +-23040 with flip
  function automatic fold_t fold(input logic signed [AngleWidth-1:0] h);
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] r;
    logic [16:0]             rr;
    fold_t                   f;
    p = ProdW'(h) * $signed({1'b0, TurnRecip});
    r = ProdW'(h) - (p >>> RecipSh) * TurnS;
    if (r < 0) r = r + TurnS;
    if (r >= TurnS) r = r - TurnS;
    rr = r[16:0];
    f.flip = 1'b0;
    f.r = rr;
    if (rr > 17'(QuarterUnits)) begin
      if (rr <= 17'(TurnUnits - QuarterUnits)) begin
        f.r = rr - 17'(HalfUnits);
        f.flip = 1'b1;
      end else begin
        f.r = rr - 17'(TurnUnits);
      end
    end
    return f;
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q.roll  <= fold(roll_i);
      item_q.pitch <= fold(pitch_i);
      item_q.yaw   <= fold(yaw_i);
    end
  end

endmodule

// ----- hdl/e2q_queue.sv -----
module e2q_queue import e2q_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t item_i,
  output logic   valid_o,
  input  logic   ready_i,
  output front_t item_o
);

  front_t             mem_q [QueueDepth];
  logic [QueueAw-1:0] wptr_q, rptr_q;
  logic [QueueAw:0]   cnt_q;
  logic               push, pop;

  assign ready_o = cnt_q != (QueueAw+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= item_i;
  end

endmodule

// ----- hdl/e2q_back.sv -----
module e2q_back import e2q_pkg::*; #(
  parameter int unsigned OutputWidth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  front_t                        item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [OutputWidth-1:0] w_o,
  output logic signed [OutputWidth-1:0] x_o,
  output logic signed [OutputWidth-1:0] y_o,
  output logic signed [OutputWidth-1:0] z_o
);

  // stage 0 theta, stages 1..24 cordic, 25 flip, 26 pair products,
  // 27 triple products, 28 sums and output register
  localparam int unsigned Stages = CordicSteps + 5;
  localparam int unsigned Sh = 61 - OutputWidth;

  logic [Stages-1:0] vld_q;
  logic              adv;

  assign valid_o = vld_q[Stages-1];
  assign adv     = !valid_o || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  cval_t cx_q [3][CordicSteps+1];
  cval_t cy_q [3][CordicSteps+1];
  cval_t cz_q [3][CordicSteps+1];
  logic  fl_q [3][CordicSteps+1];
  cval_t c_q [3];
  cval_t s_q [3];
  fold_t ang [3];

  assign ang[0] = item_i.roll;
  assign ang[1] = item_i.pitch;
  assign ang[2] = item_i.yaw;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [51:0] th;
    assign th = 52'($signed(ang[a].r)) * $signed({1'b0, DegToRadQ46}) + 52'sd32768;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[a][0] <= CordicGainInv;
        cy_q[a][0] <= '0;
        cz_q[a][0] <= 34'(th >>> 16);
        fl_q[a][0] <= ang[a].flip;
      end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (adv) begin
          fl_q[a][i+1] <= fl_q[a][i];
          if (!cz_q[a][i][33]) begin
            cx_q[a][i+1] <= cx_q[a][i] - (cy_q[a][i] >>> i);
            cy_q[a][i+1] <= cy_q[a][i] + (cx_q[a][i] >>> i);
            cz_q[a][i+1] <= cz_q[a][i] - atan_q30(5'(i));
          end else begin
            cx_q[a][i+1] <= cx_q[a][i] + (cy_q[a][i] >>> i);
            cy_q[a][i+1] <= cy_q[a][i] - (cx_q[a][i] >>> i);
            cz_q[a][i+1] <= cz_q[a][i] + atan_q30(5'(i));
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[a] <= fl_q[a][CordicSteps] ? -cx_q[a][CordicSteps] : cx_q[a][CordicSteps];
        s_q[a] <= fl_q[a][CordicSteps] ? -cy_q[a][CordicSteps] : cy_q[a][CordicSteps];
      end
    end
  end

  function automatic cval_t mq30(input cval_t a, input cval_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return 34'(p >>> 30);
  endfunction

  cval_t cc_q, ss_q, sc_q, cs_q, cy3_q, sy3_q;
  logic signed [67:0] p_q [8];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cc_q  <= mq30(c_q[0], c_q[1]);
      ss_q  <= mq30(s_q[0], s_q[1]);
      sc_q  <= mq30(s_q[0], c_q[1]);
      cs_q  <= mq30(c_q[0], s_q[1]);
      cy3_q <= c_q[2];
      sy3_q <= s_q[2];
      p_q[0] <= 68'(cc_q) * 68'(cy3_q);
      p_q[1] <= 68'(ss_q) * 68'(sy3_q);
      p_q[2] <= 68'(sc_q) * 68'(cy3_q);
      p_q[3] <= 68'(cs_q) * 68'(sy3_q);
      p_q[4] <= 68'(cs_q) * 68'(cy3_q);
      p_q[5] <= 68'(sc_q) * 68'(sy3_q);
      p_q[6] <= 68'(cc_q) * 68'(sy3_q);
      p_q[7] <= 68'(ss_q) * 68'(cy3_q);
    end
  end

  function automatic logic signed [OutputWidth-1:0] sat(input logic signed [67:0] q);
    logic signed [67:0] v;
    logic signed [67:0] hi, lo;
    v  = (q + (68'sd1 <<< (Sh - 1))) >>> Sh;
    hi = (68'sd1 <<< (OutputWidth - 1)) - 68'sd1;
    lo = -hi - 68'sd1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OutputWidth-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_o <= sat(p_q[0] + p_q[1]);
      x_o <= sat(p_q[2] - p_q[3]);
      y_o <= sat(p_q[4] + p_q[5]);
      z_o <= sat(p_q[6] - p_q[7]);
    end
  end

endmodule

// ----- hdl/euler_to_quaternion.sv -----
// path from input transfer to result: front register, queue, 29 back stages
// throughput: one orientation per cycle while results are taken; the cordic pipeline and products are fully staged
// the back pipeline stalls as a whole when the result is not taken; the queue absorbs
// items already in the front register
// reset: asynchronous active low, clears all valid flags and queue pointers
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion import e2q_pkg::*; #(
  parameter int unsigned ANGLE_WIDTH = 17,
  parameter int unsigned OUTPUT_WIDTH = 16
) (
  input logic  clk_i,
  input logic  rst_ni,
  e2q_stream_if.sink   in_if,
  e2q_stream_if.source out_if
);

  logic   f_valid, f_ready, q_valid, q_ready;
  front_t f_item, q_item;
  logic signed [OUTPUT_WIDTH-1:0] w, x, y, z;

  e2q_front #(.AngleWidth(ANGLE_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .roll_i  (in_if.data[ANGLE_WIDTH-1:0]),
    .pitch_i (in_if.data[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
    .yaw_i   (in_if.data[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .item_o  (f_item)
  );

  e2q_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i (f_valid),
    .ready_o (f_ready),
    .item_i  (f_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  e2q_back #(.OutputWidth(OUTPUT_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid),
    .ready_o (q_ready),
    .item_i  (q_item),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .w_o (w), .x_o (x), .y_o (y), .z_o (z)
  );

  assign out_if.data = {z, y, x, w};

  `E2Q_ASSERT_NEXT(a_out_hold, out_if.valid && !out_if.ready, out_if.valid, "result dropped")
  `E2Q_ASSERT(a_queue_flow, !(q_valid && !q_ready) || out_if.valid, "back stalled without result")
  `E2Q_ASSERT_NEXT(a_front_stall, f_valid && !f_ready, f_valid && $stable(f_item), "front lost")

endmodule
